/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion wrappers used by srit_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion that is off while reset is held
`define SRIT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assertion that also watches the reset cycles
`define SRIT_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/srit_pkg.sv */
// ----------------------------------------------------------------------------
// srit_pkg
// shared constants and types of the segment / rectangle intersection test
// ----------------------------------------------------------------------------
package srit_pkg;

    localparam int C_COORD_BITS      = 18;
    localparam int C_SLOPE_FRAC_BITS = 10;

    typedef struct packed {
        logic valid;
        logic decided;
        logic dhit;
        logic neg_x;
        logic neg_z;
    } t_flags;

endpackage

/* rtl/core/srit_if.sv */
// ----------------------------------------------------------------------------
// srit_seg_if / srit_hit_if
// valid / ready channels for query words and hit words
// ----------------------------------------------------------------------------
interface srit_seg_if #(
    parameter int W = 18
) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] rect_left;
    logic signed [W-1:0] rect_right;
    logic signed [W-1:0] rect_top;
    logic signed [W-1:0] rect_bottom;
    logic signed [W-1:0] seg_x0;
    logic signed [W-1:0] seg_x1;
    logic signed [W-1:0] seg_z0;
    logic signed [W-1:0] seg_z1;

    modport source (
        output valid, rect_left, rect_right, rect_top, rect_bottom,
               seg_x0, seg_x1, seg_z0, seg_z1,
        input  ready
    );
    modport sink (
        input  valid, rect_left, rect_right, rect_top, rect_bottom,
               seg_x0, seg_x1, seg_z0, seg_z1,
        output ready
    );
endinterface

interface srit_hit_if ();
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink (input valid, hit, output ready);
endinterface

/* rtl/core/srit_div_cell.sv */
// ----------------------------------------------------------------------------
// srit_div_cell
// one restoring divide step for both slopes, plus pass-along context
// ----------------------------------------------------------------------------
module srit_div_cell
    import srit_pkg::*;
#(
    parameter int C    = C_COORD_BITS,
    parameter int Q    = C_COORD_BITS + C_SLOPE_FRAC_BITS,
    parameter int CTXW = 8 * C_COORD_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  t_flags          i_flags,
    input  logic [C-1:0]    i_rem_x,
    input  logic [Q-1:0]    i_num_x,
    input  logic [C-1:0]    i_den_x,
    input  logic [C-1:0]    i_rem_z,
    input  logic [Q-1:0]    i_num_z,
    input  logic [C-1:0]    i_den_z,
    input  logic [CTXW-1:0] i_ctx,
    output t_flags          o_flags,
    output logic [C-1:0]    o_rem_x,
    output logic [Q-1:0]    o_num_x,
    output logic [C-1:0]    o_den_x,
    output logic [C-1:0]    o_rem_z,
    output logic [Q-1:0]    o_num_z,
    output logic [C-1:0]    o_den_z,
    output logic [CTXW-1:0] o_ctx
);

    logic [C:0]   w_t_x, w_t_z, w_d_x, w_d_z;
    logic         w_ge_x, w_ge_z;
    t_flags       r_flags;
    logic [C-1:0] r_rem_x, r_rem_z, r_den_x, r_den_z;
    logic [Q-1:0] r_num_x, r_num_z;
    logic [CTXW-1:0] r_ctx;

    always_comb begin
        w_t_x  = {i_rem_x, i_num_x[Q-1]};
        w_t_z  = {i_rem_z, i_num_z[Q-1]};
        w_ge_x = w_t_x >= {1'b0, i_den_x};
        w_ge_z = w_t_z >= {1'b0, i_den_z};
        w_d_x  = w_t_x - {1'b0, i_den_x};
        w_d_z  = w_t_z - {1'b0, i_den_z};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_en) begin
            r_flags <= i_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem_x <= w_ge_x ? w_d_x[C-1:0] : w_t_x[C-1:0];
            r_rem_z <= w_ge_z ? w_d_z[C-1:0] : w_t_z[C-1:0];
            r_num_x <= {i_num_x[Q-2:0], w_ge_x};
            r_num_z <= {i_num_z[Q-2:0], w_ge_z};
            r_den_x <= i_den_x;
            r_den_z <= i_den_z;
            r_ctx   <= i_ctx;
        end
    end

    assign o_flags = r_flags;
    assign o_rem_x = r_rem_x;
    assign o_num_x = r_num_x;
    assign o_den_x = r_den_x;
    assign o_rem_z = r_rem_z;
    assign o_num_z = r_num_z;
    assign o_den_z = r_den_z;
    assign o_ctx   = r_ctx;

endmodule

/* rtl/core/srit_cross.sv */
// ----------------------------------------------------------------------------
// srit_cross
// edge crossing products, then range compares and the final hit word
// ----------------------------------------------------------------------------
module srit_cross
    import srit_pkg::*;
#(
    parameter int C = C_COORD_BITS,
    parameter int F = C_SLOPE_FRAC_BITS,
    parameter int Q = C_COORD_BITS + C_SLOPE_FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  t_flags              i_flags,
    input  logic [Q-1:0]        i_quo_x,
    input  logic [Q-1:0]        i_quo_z,
    input  logic signed [C-1:0] i_left,
    input  logic signed [C-1:0] i_right,
    input  logic signed [C-1:0] i_top,
    input  logic signed [C-1:0] i_bottom,
    input  logic signed [C-1:0] i_ax1,
    input  logic signed [C-1:0] i_az1,
    input  logic signed [C-1:0] i_ax2,
    input  logic signed [C-1:0] i_az2,
    output logic                o_valid,
    output logic                o_hit
);

    localparam int PE = Q + C + 2;
    localparam int PW = (PE > 64) ? 64 : PE;

    logic signed [Q:0]    w_k_x, w_k_z;
    logic signed [C:0]    w_d [4];
    logic signed [PE-1:0] r_prod [4];
    logic signed [C-1:0]  r_p0 [4];
    logic signed [C-1:0]  r_lo [4];
    logic signed [C-1:0]  r_hi [4];
    t_flags               r_m_flags;
    logic signed [PW-1:0] w_pt [4];
    logic signed [PW-1:0] w_sh [4];
    logic signed [63:0]   w_sum [4];
    logic [3:0]           w_in;
    logic                 r_h_valid, r_h_hit;

    always_comb begin
        w_k_x = i_flags.neg_x ? -$signed({1'b0, i_quo_x}) : $signed({1'b0, i_quo_x});
        w_k_z = i_flags.neg_z ? -$signed({1'b0, i_quo_z}) : $signed({1'b0, i_quo_z});
        w_d[0] = (C+1)'(i_left)   - (C+1)'(i_ax1);
        w_d[1] = (C+1)'(i_right)  - (C+1)'(i_ax1);
        w_d[2] = (C+1)'(i_top)    - (C+1)'(i_az2);
        w_d[3] = (C+1)'(i_bottom) - (C+1)'(i_az2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_flags <= '0;
        end else if (i_en) begin
            r_m_flags <= i_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod[0] <= w_k_x * w_d[0];
            r_prod[1] <= w_k_x * w_d[1];
            r_prod[2] <= w_k_z * w_d[2];
            r_prod[3] <= w_k_z * w_d[3];
            r_p0[0]   <= i_az1;
            r_p0[1]   <= i_az1;
            r_p0[2]   <= i_ax2;
            r_p0[3]   <= i_ax2;
            r_lo[0]   <= i_top;
            r_lo[1]   <= i_top;
            r_lo[2]   <= i_left;
            r_lo[3]   <= i_left;
            r_hi[0]   <= i_bottom;
            r_hi[1]   <= i_bottom;
            r_hi[2]   <= i_right;
            r_hi[3]   <= i_right;
        end
    end

    // product is cut to 64 bits when wider, shift is arithmetic
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_pt[i]  = $signed(r_prod[i][PW-1:0]);
            w_sh[i]  = w_pt[i] >>> F;
            w_sum[i] = 64'(w_sh[i]) + 64'(r_p0[i]);
            w_in[i]  = (w_sum[i] >= 64'(r_lo[i])) && (w_sum[i] <= 64'(r_hi[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_valid <= 1'b0;
        end else if (i_en) begin
            r_h_valid <= r_m_flags.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h_hit <= r_m_flags.decided ? r_m_flags.dhit : (|w_in);
        end
    end

    assign o_valid = r_h_valid;
    assign o_hit   = r_h_hit;

endmodule

/* rtl/core/segment_rect_intersect_test.sv */
// ----------------------------------------------------------------------------
// segment_rect_intersect_test
// line segment against axis-aligned rectangle hit test, fully pipelined
//
//   channel   dir  word
//   i_seg     in   rect_left/right/top/bottom, seg_x0/x1/z0/z1
//   o_res     out  hit
//
// one word accepted per cycle while the output is not stalled; a word passes
// the input register, a row of divide cells, one quotient bit per cell, for
// both slopes side by side, then a product register and a hit register
// synchronous active-low reset empties the pipe
// a stalled output freezes the whole pipe; i_seg.ready is low only then
// ----------------------------------------------------------------------------
module segment_rect_intersect_test
    import srit_pkg::*;
#(
    parameter int COORD_BITS      = C_COORD_BITS,
    parameter int SLOPE_FRAC_BITS = C_SLOPE_FRAC_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    srit_seg_if.sink   i_seg,
    srit_hit_if.source o_res
);

    localparam int C    = COORD_BITS;
    localparam int F    = SLOPE_FRAC_BITS;
    localparam int Q    = C + F;
    localparam int CTXW = 8 * C;

    logic w_en;

    logic signed [C-1:0] w_l, w_r, w_t, w_b, w_ax, w_bx, w_az, w_bz;
    logic signed [C-1:0] w_ax1, w_bx1, w_az1, w_bz1, w_ax2, w_bx2, w_az2, w_bz2;
    logic signed [C:0]   w_dx, w_dz, w_nx, w_nz;
    logic [C-1:0]        w_mag_x, w_mag_z;
    logic                w_rej, w_ins, w_hz, w_vt;
    t_flags              w_flags;

    t_flags          r_a_flags;
    logic [Q-1:0]    r_a_num_x, r_a_num_z;
    logic [C-1:0]    r_a_den_x, r_a_den_z;
    logic [CTXW-1:0] r_a_ctx;

    t_flags          w_c_flags [0:Q];
    logic [C-1:0]    w_c_rem_x [0:Q];
    logic [Q-1:0]    w_c_num_x [0:Q];
    logic [C-1:0]    w_c_den_x [0:Q];
    logic [C-1:0]    w_c_rem_z [0:Q];
    logic [Q-1:0]    w_c_num_z [0:Q];
    logic [C-1:0]    w_c_den_z [0:Q];
    logic [CTXW-1:0] w_c_ctx   [0:Q];

    logic w_out_valid;

    assign w_en        = !w_out_valid || o_res.ready;
    assign i_seg.ready = w_en;
    assign o_res.valid = w_out_valid;

    always_comb begin
        w_l  = i_seg.rect_left;
        w_r  = i_seg.rect_right;
        w_t  = i_seg.rect_top;
        w_b  = i_seg.rect_bottom;
        w_ax = i_seg.seg_x0;
        w_bx = i_seg.seg_x1;
        w_az = i_seg.seg_z0;
        w_bz = i_seg.seg_z1;

        w_rej = (w_ax > w_r && w_bx > w_r) || (w_ax < w_l && w_bx < w_l) ||
                (w_az > w_b && w_bz > w_b) || (w_az < w_t && w_bz < w_t);
        w_ins = (w_ax >= w_l && w_ax <= w_r && w_az >= w_t && w_az <= w_b) ||
                (w_bx >= w_l && w_bx <= w_r && w_bz >= w_t && w_bz <= w_b);
        w_hz  = w_az == w_bz;
        w_vt  = w_ax == w_bx;

        // endpoints ordered by x for the side edges
        if (w_ax > w_bx) begin
            w_ax1 = w_bx; w_bx1 = w_ax; w_az1 = w_bz; w_bz1 = w_az;
        end else begin
            w_ax1 = w_ax; w_bx1 = w_bx; w_az1 = w_az; w_bz1 = w_bz;
        end
        // endpoints ordered by z for the top and bottom edges
        if (w_az1 > w_bz1) begin
            w_ax2 = w_bx1; w_bx2 = w_ax1; w_az2 = w_bz1; w_bz2 = w_az1;
        end else begin
            w_ax2 = w_ax1; w_bx2 = w_bx1; w_az2 = w_az1; w_bz2 = w_bz1;
        end

        w_dx    = (C+1)'(w_bx1) - (C+1)'(w_ax1);
        w_dz    = (C+1)'(w_bz2) - (C+1)'(w_az2);
        w_nx    = (C+1)'(w_bz1) - (C+1)'(w_az1);
        w_nz    = (C+1)'(w_bx2) - (C+1)'(w_ax2);
        w_mag_x = w_nx[C] ? C'(-w_nx) : w_nx[C-1:0];
        w_mag_z = w_nz[C] ? C'(-w_nz) : w_nz[C-1:0];

        w_flags.valid   = i_seg.valid;
        w_flags.decided = w_rej || w_ins || w_hz || w_vt;
        w_flags.dhit    = !w_rej && (w_ins ||
                          (w_hz ? (w_t <= w_az && w_b >= w_az) :
                                  (w_l <= w_ax && w_r >= w_ax)));
        w_flags.neg_x   = w_nx[C];
        w_flags.neg_z   = w_nz[C];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_flags <= '0;
        end else if (w_en) begin
            r_a_flags <= w_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_num_x <= {w_mag_x, F'(0)};
            r_a_num_z <= {w_mag_z, F'(0)};
            r_a_den_x <= w_dx[C-1:0];
            r_a_den_z <= w_dz[C-1:0];
            r_a_ctx   <= {w_l, w_r, w_t, w_b, w_ax1, w_az1, w_ax2, w_az2};
        end
    end

    assign w_c_flags[0] = r_a_flags;
    assign w_c_rem_x[0] = '0;
    assign w_c_num_x[0] = r_a_num_x;
    assign w_c_den_x[0] = r_a_den_x;
    assign w_c_rem_z[0] = '0;
    assign w_c_num_z[0] = r_a_num_z;
    assign w_c_den_z[0] = r_a_den_z;
    assign w_c_ctx[0]   = r_a_ctx;

    for (genvar g = 0; g < Q; g++) begin : g_cell
        srit_div_cell #(
            .C    (C),
            .Q    (Q),
            .CTXW (CTXW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_flags (w_c_flags[g]),
            .i_rem_x (w_c_rem_x[g]),
            .i_num_x (w_c_num_x[g]),
            .i_den_x (w_c_den_x[g]),
            .i_rem_z (w_c_rem_z[g]),
            .i_num_z (w_c_num_z[g]),
            .i_den_z (w_c_den_z[g]),
            .i_ctx   (w_c_ctx[g]),
            .o_flags (w_c_flags[g+1]),
            .o_rem_x (w_c_rem_x[g+1]),
            .o_num_x (w_c_num_x[g+1]),
            .o_den_x (w_c_den_x[g+1]),
            .o_rem_z (w_c_rem_z[g+1]),
            .o_num_z (w_c_num_z[g+1]),
            .o_den_z (w_c_den_z[g+1]),
            .o_ctx   (w_c_ctx[g+1])
        );
    end

    srit_cross #(
        .C (C),
        .F (F),
        .Q (Q)
    ) u_cross (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_flags  (w_c_flags[Q]),
        .i_quo_x  (w_c_num_x[Q]),
        .i_quo_z  (w_c_num_z[Q]),
        .i_left   (w_c_ctx[Q][8*C-1:7*C]),
        .i_right  (w_c_ctx[Q][7*C-1:6*C]),
        .i_top    (w_c_ctx[Q][6*C-1:5*C]),
        .i_bottom (w_c_ctx[Q][5*C-1:4*C]),
        .i_ax1    (w_c_ctx[Q][4*C-1:3*C]),
        .i_az1    (w_c_ctx[Q][3*C-1:2*C]),
        .i_ax2    (w_c_ctx[Q][2*C-1:C]),
        .i_az2    (w_c_ctx[Q][C-1:0]),
        .o_valid  (w_out_valid),
        .o_hit    (o_res.hit)
    );

endmodule

/* rtl/core/srit_checker.sv */
// ----------------------------------------------------------------------------
// srit_checker
// port-level checks of the hit test, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module srit_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_hit
);

    `SRIT_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid, "word after reset")
    `SRIT_ASSERT(a_ready_free, i_clk, i_rst_n, !i_out_valid |-> i_in_ready, "ready low with empty output")
    `SRIT_ASSERT(a_stall_ready, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |-> !i_in_ready, "input taken during stall")
    `SRIT_ASSERT(a_hold_valid, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> i_out_valid, "word dropped")
    `SRIT_ASSERT(a_hold_hit, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> $stable(i_out_hit), "hit changed in stall")

endmodule

bind segment_rect_intersect_test srit_checker u_srit_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_seg.valid),
    .i_in_ready  (i_seg.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_hit   (o_res.hit)
);
